FILE: src/rdvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdvc_pkg
// Types and fixed constants shared by the recent distinct value cache.
// ----------------------------------------------------------------------------
package rdvc_pkg;

    localparam int VALUE_W     = 31;
    localparam int CFG_W       = 5;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               seq_end;
    } rdvc_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] entry_value;
        logic               is_last;
        logic               is_empty;
    } rdvc_result_t;

    // command passed from the front end to the stack engine
    typedef struct packed {
        logic               is_end;
        logic [VALUE_W-1:0] value;
    } rdvc_cmd_t;

endpackage

FILE: src/rdvc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdvc_front
// Input stage: takes items, drops zero data values, and registers the rest
// as commands for the queue.
// ----------------------------------------------------------------------------
module rdvc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rdvc_pkg::rdvc_item_t in_data,
    output logic                push_valid,
    input  logic                push_ready,
    output rdvc_pkg::rdvc_cmd_t push_cmd
);
    import rdvc_pkg::*;

    logic      stage_valid_reg;
    logic      stage_valid_next;
    rdvc_cmd_t stage_cmd_reg;
    logic      accept;
    logic      keep_item;
    logic      push;

    assign in_ready   = !stage_valid_reg || push_ready;
    assign accept     = in_valid && in_ready;
    // zero data values leave no trace
    assign keep_item  = in_data.seq_end || (in_data.value != '0);
    assign push       = stage_valid_reg && push_ready;
    assign push_valid = stage_valid_reg;
    assign push_cmd   = stage_cmd_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (push)
        begin
            stage_valid_next = 1'b0;
        end
        if (accept && keep_item)
        begin
            stage_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep_item)
        begin
            stage_cmd_reg.is_end <= in_data.seq_end;
            stage_cmd_reg.value  <= in_data.value;
        end
    end

endmodule

FILE: src/rdvc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdvc_queue
// Short command queue between the front end and the stack engine.
// ----------------------------------------------------------------------------
module rdvc_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  rdvc_pkg::rdvc_cmd_t push_cmd,
    output logic                pop_valid,
    input  logic                pop_ready,
    output rdvc_pkg::rdvc_cmd_t pop_cmd
);
    import rdvc_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    rdvc_cmd_t       slots_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [NW-1:0]   fill_reg;
    logic [NW-1:0]   fill_next;
    logic            push;
    logic            pop;

    assign push_ready = (fill_reg != NW'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_cmd    = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: src/rdvc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdvc_back
// Recency stack engine: move-to-front update for data commands, one result
// per cycle dump for end commands unless stalled, and the result register.
// ----------------------------------------------------------------------------
module rdvc_back
#(
    parameter int STACK_DEPTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [rdvc_pkg::CFG_W-1:0] cfg_data,
    input  logic                   cmd_valid,
    output logic                   cmd_ready,
    input  rdvc_pkg::rdvc_cmd_t    cmd,
    output logic                   out_valid,
    input  logic                   out_ready,
    output rdvc_pkg::rdvc_result_t out_data
);
    import rdvc_pkg::*;

    localparam int CW        = $clog2(STACK_DEPTH + 1);
    localparam int EW        = (CW > CFG_W) ? CW : CFG_W;
    localparam int LIM_RESET = (16 > STACK_DEPTH) ? STACK_DEPTH : 16;

    logic [VALUE_W-1:0] entries_reg  [STACK_DEPTH];
    logic [VALUE_W-1:0] entries_next [STACK_DEPTH];
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      lim_reg;
    logic [CW-1:0]      lim_cfg;
    logic               dumping_reg;
    logic               dumping_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    rdvc_result_t       out_data_reg;
    rdvc_result_t       load_data;
    logic               load;
    logic               slot_free;
    logic               pop;
    logic               do_record;
    logic               do_dump;
    logic               do_empty;
    logic               entries_en;
    logic [STACK_DEPTH-1:0] hit;
    logic               any_hit;
    logic [CW-1:0]      hit_pos;
    logic [CW-1:0]      miss_pos;
    logic [CW-1:0]      pos;
    logic [EW-1:0]      cfg_ext;

    assign slot_free = !out_valid_reg || out_ready;
    assign cmd_ready = !dumping_reg && (!cmd.is_end || slot_free);
    assign pop       = cmd_valid && cmd_ready;
    assign do_record = pop && !cmd.is_end;
    assign do_empty  = pop && cmd.is_end && (count_reg == '0);
    // first step of a dump runs in the same cycle the end command is taken
    assign do_dump   = (dumping_reg && slot_free)
                    || (pop && cmd.is_end && (count_reg != '0));
    assign load      = do_empty || do_dump;
    assign entries_en = do_record || do_dump;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // clamp the register to the range 1 .. STACK_DEPTH
    always_comb
    begin
        cfg_ext = EW'(cfg_data);
        if (cfg_ext == '0)
        begin
            lim_cfg = CW'(1);
        end
        else if (cfg_ext > EW'(STACK_DEPTH))
        begin
            lim_cfg = CW'(STACK_DEPTH);
        end
        else
        begin
            lim_cfg = CW'(cfg_ext);
        end
    end

    // parallel match against the valid entries
    always_comb
    begin
        hit_pos = '0;
        for (int k = 0; k < STACK_DEPTH; k++)
        begin
            hit[k] = (CW'(k) < count_reg) && (entries_reg[k] == cmd.value);
            if (hit[k])
            begin
                hit_pos = hit_pos | CW'(k);
            end
        end
        any_hit  = |hit;
        miss_pos = (count_reg < lim_reg) ? count_reg : count_reg - 1'b1;
        pos      = any_hit ? hit_pos : miss_pos;
    end

    always_comb
    begin
        for (int k = 0; k < STACK_DEPTH; k++)
        begin
            entries_next[k] = entries_reg[k];
        end
        if (do_record)
        begin
            entries_next[0] = cmd.value;
            for (int k = 1; k < STACK_DEPTH; k++)
            begin
                if (CW'(k) <= pos)
                begin
                    entries_next[k] = entries_reg[k-1];
                end
            end
        end
        else if (do_dump)
        begin
            // pop the newest entry off the top
            for (int k = 0; k < STACK_DEPTH - 1; k++)
            begin
                entries_next[k] = entries_reg[k+1];
            end
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        dumping_next = dumping_reg;
        load_data    = '0;
        if (do_record && !any_hit && (count_reg < lim_reg))
        begin
            count_next = count_reg + 1'b1;
        end
        if (do_empty)
        begin
            load_data.entry_value = '0;
            load_data.is_last     = 1'b1;
            load_data.is_empty    = 1'b1;
        end
        else if (do_dump)
        begin
            load_data.entry_value = entries_reg[0];
            load_data.is_last     = (count_reg == CW'(1));
            load_data.is_empty    = 1'b0;
            count_next            = count_reg - 1'b1;
            dumping_next          = (count_reg != CW'(1));
        end
        // lowering the limit drops the oldest entries
        if (cfg_valid && (count_reg > lim_cfg))
        begin
            count_next = lim_cfg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            lim_reg       <= CW'(LIM_RESET);
            dumping_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            dumping_reg   <= dumping_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                lim_reg <= lim_cfg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (entries_en)
        begin
            for (int k = 0; k < STACK_DEPTH; k++)
            begin
                entries_reg[k] <= entries_next[k];
            end
        end
        if (load)
        begin
            out_data_reg <= load_data;
        end
    end

    a_count_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= lim_reg)
        else $error("stack fill exceeds the active limit");

    a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        dumping_reg |-> (count_reg != '0))
        else $error("dump running on an empty stack");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.is_empty) |-> out_data_reg.is_last)
        else $error("empty result not marked last");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (load && load_data.is_last) |=> ((count_reg == '0) && !dumping_reg))
        else $error("stack not cleared after the last result");

endmodule

FILE: src/recent_distinct_value_cache_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recent_distinct_value_cache_core
// Move-to-front recency stack of the most recent distinct nonzero values.
// ----------------------------------------------------------------------------
// Takes one item per cycle while in_ready is high. A data item is matched
// against every stored entry in parallel and updates the stack; zero values
// are dropped at the input. An end item dumps the stored values newest
// first, one result per cycle while the output is ready, and an empty stack
// gives a single result flagged empty; a four-entry command queue keeps the
// input side taking items during a dump. An end item passes through the
// input stage register and the command queue before the stack engine loads
// its first result into the result register, and the rest follow one per
// cycle while the output is ready. The limit register may only be written
// while no item is in flight; lowering it drops the oldest entries.
module recent_distinct_value_cache_core
#(
    parameter int STACK_DEPTH = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  rdvc_pkg::rdvc_item_t       in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output rdvc_pkg::rdvc_result_t     out_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [rdvc_pkg::CFG_W-1:0] cfg_data
);
    import rdvc_pkg::*;

    logic      push_valid;
    logic      push_ready;
    rdvc_cmd_t push_cmd;
    logic      pop_valid;
    logic      pop_ready;
    rdvc_cmd_t pop_cmd;

    assign cfg_ready = 1'b1;

    rdvc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    rdvc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    rdvc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .cmd_valid  (pop_valid),
        .cmd_ready  (pop_ready),
        .cmd        (pop_cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
